[src/adenv_pkg.sv]
// Shared types, constants and helpers for the audio ducking envelope.
package adenv_pkg;

   // Field widths
   localparam int SAMPLE_BITS   = 16;
   localparam int GAIN_BITS     = 17;
   localparam int VOL_BITS      = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 17;

   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(65536);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUCK_ENABLE  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUCK_LEVEL   = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_ATTACK_COEF  = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELEASE_COEF = CSR_IDX_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_VOLUME  = CSR_IDX_BITS'(4);

   // Register reset values
   localparam logic [GAIN_BITS-1:0] DUCK_LEVEL_RST   = GAIN_BITS'(22938);
   localparam logic [GAIN_BITS-1:0] ATTACK_COEF_RST  = GAIN_BITS'(27);
   localparam logic [GAIN_BITS-1:0] RELEASE_COEF_RST = GAIN_BITS'(5);
   localparam logic [VOL_BITS-1:0]  BASE_VOLUME_RST  = VOL_BITS'(4096);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic                          voice_active;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic [GAIN_BITS-1:0]          gain_out;
   } rsp_type;

   // Configuration registers as seen by front and back
   typedef struct packed {
      logic                 duck_enable;
      logic [GAIN_BITS-1:0] duck_level;
      logic [GAIN_BITS-1:0] attack_coef;
      logic [GAIN_BITS-1:0] release_coef;
      logic [VOL_BITS-1:0]  base_volume;
   } cfg_type;

   // One queued frame: raw samples and the gain to apply
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic [GAIN_BITS-1:0]          gain;
   } qent_type;

   // Clamp a Q1.16 value to unity
   function automatic logic [GAIN_BITS-1:0] sat_unity(input logic [GAIN_BITS-1:0] v);
      return (v > UNITY_GAIN) ? UNITY_GAIN : v;
   endfunction

endpackage

[src/adenv_queue.sv]
// Short frame queue between the envelope front and the scaling back.
module adenv_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  adenv_pkg::qent_type push_data,
   output logic                full,
   input  logic                pop,
   output adenv_pkg::qent_type pop_data,
   output logic                empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   adenv_pkg::qent_type entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Front never writes a full queue, back never reads an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");

endmodule

[src/adenv_front.sv]
// Envelope front: accepts frames, steps the attack/release gain, queues the frame.
module adenv_front (
   input  logic                clock,
   input  logic                reset,
   input  adenv_pkg::cfg_type  cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  adenv_pkg::req_type  req_data,
   input  logic                q_full,
   output logic                push,
   output adenv_pkg::qent_type push_data
);

   localparam int GB        = adenv_pkg::GAIN_BITS;
   localparam int PROD_BITS = 2 * GB;
   localparam int STEP_BITS = PROD_BITS + 1 - 16;

   logic [GB-1:0]        gain_ff, gain_in;
   logic [GB-1:0]        target;
   logic                 falling;
   logic [GB-1:0]        coef;
   logic [GB-1:0]        dmag;
   logic [PROD_BITS-1:0] prod;
   logic [PROD_BITS:0]   prod_rnd;
   logic [STEP_BITS-1:0] step_raw;
   logic [GB-1:0]        step;
   logic                 accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // One-pole step toward the target, rounded, at least one LSB, never past it
   always_comb begin
      target   = req_data.voice_active ? adenv_pkg::sat_unity(cfg.duck_level)
                                       : adenv_pkg::UNITY_GAIN;
      falling  = (target < gain_ff);
      coef     = adenv_pkg::sat_unity(falling ? cfg.attack_coef : cfg.release_coef);
      dmag     = falling ? (gain_ff - target) : (target - gain_ff);
      prod     = PROD_BITS'(coef) * PROD_BITS'(dmag);
      prod_rnd = {1'b0, prod} + (PROD_BITS + 1)'(32768);
      step_raw = prod_rnd[PROD_BITS:16];
      if (step_raw == '0) begin
         step = GB'(1);
      end else if (step_raw > STEP_BITS'(dmag)) begin
         step = dmag;
      end else begin
         step = step_raw[GB-1:0];
      end
      if (step > dmag) begin
         step = dmag;
      end
      gain_in = falling ? (gain_ff - step) : (gain_ff + step);
   end

   // Queue beat
   assign push           = accept;
   assign push_data.left  = req_data.left_in;
   assign push_data.right = req_data.right_in;
   assign push_data.gain  = cfg.duck_enable ? gain_in : adenv_pkg::UNITY_GAIN;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= adenv_pkg::UNITY_GAIN;
      end else if (accept) begin
         gain_ff <= gain_in;
      end
   end

   a_gain_le_unity: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= adenv_pkg::UNITY_GAIN)
      else $error("envelope gain above unity");
   a_gain_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> gain_ff == $past(gain_ff))
      else $error("envelope gain moved without a beat");
   a_unity_when_off: assert property (@(posedge clock) disable iff (reset)
      (push && !cfg.duck_enable) |-> push_data.gain == adenv_pkg::UNITY_GAIN)
      else $error("gain applied while ducking off");

endmodule

[src/adenv_back.sv]
// Scaling back: sample times volume times gain, rounded and saturated, into the output register.
module adenv_back (
   input  logic                clock,
   input  logic                reset,
   input  adenv_pkg::cfg_type  cfg,
   input  logic                q_empty,
   input  adenv_pkg::qent_type q_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output adenv_pkg::rsp_type  rsp_data
);

   localparam int SB        = adenv_pkg::SAMPLE_BITS;
   localparam int GB        = adenv_pkg::GAIN_BITS;
   localparam int VG_BITS   = adenv_pkg::VOL_BITS + GB;
   localparam int PROD_BITS = SB + VG_BITS;
   localparam int SHIFT     = 28;
   localparam int R_BITS    = PROD_BITS + 1 - SHIFT;
   localparam logic [R_BITS-1:0] LIM_NEG = R_BITS'(1) << (SB - 1);
   localparam logic [R_BITS-1:0] LIM_POS = LIM_NEG - R_BITS'(1);

   // Shift right by 28 with halves away from zero, then clamp and restore sign
   function automatic logic [SB-1:0] round_sat(input logic [PROD_BITS-1:0] p,
                                               input logic neg);
      logic [PROD_BITS:0] sum;
      logic [R_BITS-1:0]  r;
      sum = {1'b0, p} + ((PROD_BITS + 1)'(1) << (SHIFT - 1));
      r   = sum[PROD_BITS:SHIFT];
      if (neg) begin
         if (r > LIM_NEG) begin
            r = LIM_NEG;
         end
         return SB'(R_BITS'(0) - r);
      end
      if (r > LIM_POS) begin
         r = LIM_POS;
      end
      return r[SB-1:0];
   endfunction

   logic                 adv;
   logic                 s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic [SB-1:0]        s1_mag_l_ff, s1_mag_r_ff;
   logic                 s1_neg_l_ff, s1_neg_r_ff, s2_neg_l_ff, s2_neg_r_ff;
   logic [VG_BITS-1:0]   s1_vg_ff;
   logic [GB-1:0]        s1_gain_ff, s2_gain_ff;
   logic [PROD_BITS-1:0] s2_prod_l_ff, s2_prod_r_ff;
   adenv_pkg::rsp_type   rsp_data_ff;
   logic [SB-1:0]        mag_l_in, mag_r_in;

   // Whole pipeline moves unless a result is held by the consumer
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sample magnitudes
   assign mag_l_in = q_data.left[SB-1]  ? (SB'(0) - SB'(q_data.left))  : SB'(q_data.left);
   assign mag_r_in = q_data.right[SB-1] ? (SB'(0) - SB'(q_data.right)) : SB'(q_data.right);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: magnitudes and volume times gain
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_l_ff <= mag_l_in;
         s1_mag_r_ff <= mag_r_in;
         s1_neg_l_ff <= q_data.left[SB-1];
         s1_neg_r_ff <= q_data.right[SB-1];
         s1_vg_ff    <= VG_BITS'(cfg.base_volume) * VG_BITS'(q_data.gain);
         s1_gain_ff  <= q_data.gain;
      end
   end

   // Stage 2: magnitude times scaled gain
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_prod_l_ff <= PROD_BITS'(s1_mag_l_ff) * PROD_BITS'(s1_vg_ff);
         s2_prod_r_ff <= PROD_BITS'(s1_mag_r_ff) * PROD_BITS'(s1_vg_ff);
         s2_neg_l_ff  <= s1_neg_l_ff;
         s2_neg_r_ff  <= s1_neg_r_ff;
         s2_gain_ff   <= s1_gain_ff;
      end
   end

   // Output register: round and saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.left_out  <= round_sat(s2_prod_l_ff, s2_neg_l_ff);
         rsp_data_ff.right_out <= round_sat(s2_prod_r_ff, s2_neg_r_ff);
         rsp_data_ff.gain_out  <= s2_gain_ff;
      end
   end

endmodule

[src/audio_ducking_envelope.sv]
// An accepted req beat passes the queue, stage 1, stage 2 and the output register on its way to rsp_valid.
// Throughput: one frame per cycle unless the queue is full; the gain step (a 17x17 multiply) runs in the accept cycle.
// The back is a three-stage multiply pipeline; the queue holds QUEUE_DEPTH frames so the
// front keeps accepting while a result waits. Reset (synchronous) sets unity gain,
// the register defaults and an empty queue and pipeline; no clearing pass follows.
module audio_ducking_envelope #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  adenv_pkg::req_type                       req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output adenv_pkg::rsp_type                       rsp_data,
   input  logic                                     csr_write_en,
   input  logic [adenv_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [adenv_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   adenv_pkg::cfg_type  cfg_ff, cfg_in;
   logic                push, pop, q_full, q_empty;
   adenv_pkg::qent_type push_data, pop_data;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            adenv_pkg::CSR_DUCK_ENABLE:  cfg_in.duck_enable  = csr_wdata[0];
            adenv_pkg::CSR_DUCK_LEVEL:   cfg_in.duck_level   = csr_wdata;
            adenv_pkg::CSR_ATTACK_COEF:  cfg_in.attack_coef  = csr_wdata;
            adenv_pkg::CSR_RELEASE_COEF: cfg_in.release_coef = csr_wdata;
            adenv_pkg::CSR_BASE_VOLUME:
               cfg_in.base_volume = csr_wdata[adenv_pkg::VOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duck_enable  <= 1'b1;
         cfg_ff.duck_level   <= adenv_pkg::DUCK_LEVEL_RST;
         cfg_ff.attack_coef  <= adenv_pkg::ATTACK_COEF_RST;
         cfg_ff.release_coef <= adenv_pkg::RELEASE_COEF_RST;
         cfg_ff.base_volume  <= adenv_pkg::BASE_VOLUME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adenv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   adenv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   adenv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/audio_ducking_envelope_tb.sv]
// Self-checking bench for audio_ducking_envelope: directed script, then random setting phases.
module audio_ducking_envelope_tb;

   localparam int SAMPLE_BITS   = adenv_pkg::SAMPLE_BITS;
   localparam int GAIN_BITS     = adenv_pkg::GAIN_BITS;
   localparam int VOL_BITS      = adenv_pkg::VOL_BITS;
   localparam int CSR_IDX_BITS  = adenv_pkg::CSR_IDX_BITS;
   localparam int CSR_DATA_BITS = adenv_pkg::CSR_DATA_BITS;

   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_FRAMES   = 230;
   localparam int MAX_GAP        = 14;
   localparam int LONG_HOLD      = 150;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 12;
   localparam int NUM_REGS       = 5;
   localparam int MAX_SHOWN      = 40;

   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam longint unsigned NEG_LIMIT = 64'd1 << (SAMPLE_BITS - 1);
   localparam longint unsigned POS_LIMIT = NEG_LIMIT - 1;

   // Indexes past the register file; writes there must be dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = CSR_IDX_BITS'(NUM_REGS);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = '1;

   localparam logic [CSR_IDX_BITS-1:0] REG_ORDER [NUM_REGS] = '{
      adenv_pkg::CSR_DUCK_ENABLE, adenv_pkg::CSR_DUCK_LEVEL, adenv_pkg::CSR_ATTACK_COEF,
      adenv_pkg::CSR_RELEASE_COEF, adenv_pkg::CSR_BASE_VOLUME
   };

   localparam adenv_pkg::req_type NO_FRAME = '0;
   localparam adenv_pkg::rsp_type NO_WANT  = '0;

   typedef enum bit {ROW_FRAME, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] val;
      adenv_pkg::req_type       frame;
      bit                       typed;
      adenv_pkg::rsp_type       want;
   } script_row_type;

   // Directed script; typed rows carry their own answer, the rest use the predictor
   script_row_type script [30] = '{
      // unity gain after reset passes samples through unchanged
      '{ROW_FRAME, '0, '0, '{S_MAX, S_MIN, 1'b0}, 1'b1,
        '{S_MAX, S_MIN, adenv_pkg::UNITY_GAIN}},
      '{ROW_FRAME, '0, '0, '{16'sd0, -16'sd1, 1'b0}, 1'b1,
        '{16'sd0, -16'sd1, adenv_pkg::UNITY_GAIN}},
      // voice starts, slow attack at reset coefficients
      '{ROW_FRAME, '0, '0, '{S_MIN, S_MAX, 1'b1}, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{16'sd12345, -16'sd12345, 1'b1}, 1'b0, NO_WANT},
      // unity attack jumps straight to the duck level
      '{ROW_REG, adenv_pkg::CSR_ATTACK_COEF, 17'd65536, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{16'sd1000, -16'sd1000, 1'b1}, 1'b0, NO_WANT},
      '{ROW_REG, adenv_pkg::CSR_DUCK_LEVEL, 17'd0, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{S_MAX, S_MIN, 1'b1}, 1'b1, '{16'sd0, 16'sd0, 17'd0}},
      // level above unity clamps; zero release still creeps one LSB per frame
      '{ROW_REG, adenv_pkg::CSR_DUCK_LEVEL, 17'd131071, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_REG, adenv_pkg::CSR_RELEASE_COEF, 17'd0, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{16'sd16384, -16'sd16384, 1'b1}, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{-16'sd1, 16'sd1, 1'b1}, 1'b0, NO_WANT},
      // release above unity clamps and restores full gain in one frame
      '{ROW_REG, adenv_pkg::CSR_RELEASE_COEF, 17'd100000, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{S_MAX, S_MIN, 1'b0}, 1'b1,
        '{S_MAX, S_MIN, adenv_pkg::UNITY_GAIN}},
      // top volume saturates both rails
      '{ROW_REG, adenv_pkg::CSR_BASE_VOLUME, 17'd65535, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{S_MAX, S_MIN, 1'b0}, 1'b1,
        '{S_MAX, S_MIN, adenv_pkg::UNITY_GAIN}},
      '{ROW_FRAME, '0, '0, '{16'sd100, -16'sd100, 1'b0}, 1'b0, NO_WANT},
      // ducking off: envelope keeps tracking, unity applied
      '{ROW_REG, adenv_pkg::CSR_DUCK_ENABLE, 17'd0, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_REG, adenv_pkg::CSR_DUCK_LEVEL, 17'd30000, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{16'sd2000, -16'sd2000, 1'b1}, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{16'sd0, 16'sd0, 1'b1}, 1'b1,
        '{16'sd0, 16'sd0, adenv_pkg::UNITY_GAIN}},
      // writes past the register file change nothing
      '{ROW_REG, CSR_SPARE_LO, 17'h1FFFF, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_REG, CSR_SPARE_HI, 17'd0, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_REG, adenv_pkg::CSR_DUCK_ENABLE, 17'd1, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{S_MIN, S_MIN, 1'b1}, 1'b0, NO_WANT},
      // zero volume, then a zero attack coefficient
      '{ROW_REG, adenv_pkg::CSR_BASE_VOLUME, 17'd0, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{S_MAX, S_MIN, 1'b1}, 1'b0, NO_WANT},
      '{ROW_REG, adenv_pkg::CSR_BASE_VOLUME, 17'd4096, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_REG, adenv_pkg::CSR_ATTACK_COEF, 17'd0, NO_FRAME, 1'b0, NO_WANT},
      '{ROW_FRAME, '0, '0, '{16'sd21845, -16'sd21846, 1'b1}, 1'b0, NO_WANT}
   };

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   adenv_pkg::req_type       req_data     = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   adenv_pkg::rsp_type       rsp_data;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index    = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata    = '0;

   // Predictor state: register copy and envelope gain
   adenv_pkg::cfg_type live_cfg = '{1'b1, adenv_pkg::DUCK_LEVEL_RST,
                                    adenv_pkg::ATTACK_COEF_RST,
                                    adenv_pkg::RELEASE_COEF_RST,
                                    adenv_pkg::BASE_VOLUME_RST};
   logic [GAIN_BITS-1:0] env_gain = adenv_pkg::UNITY_GAIN;
   adenv_pkg::rsp_type ducked_due [$];

   bit steady  = 1'b0;   // both sides run without gaps
   bit rx_hold = 1'b0;   // asks the receiver for one long hold
   int frames_sent   = 0;
   int beats_checked = 0;
   int reg_writes    = 0;
   int holds_done    = 0;
   int mismatches    = 0;
   int quiet_cycles  = 0;

   audio_ducking_envelope dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // sample * volume * gain, round half away from zero, saturate
   function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(
         logic signed [SAMPLE_BITS-1:0] s, logic [VOL_BITS-1:0] vol,
         logic [GAIN_BITS-1:0] g);
      longint unsigned mag, r;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      r = (mag * vol * g + (64'd1 << 27)) >> 28;
      if (s < 0) begin
         if (r > NEG_LIMIT) r = NEG_LIMIT;
         return SAMPLE_BITS'(-r);
      end
      if (r > POS_LIMIT) r = POS_LIMIT;
      return SAMPLE_BITS'(r);
   endfunction

   // Step the envelope for one frame and work out the ducked output beat
   function automatic adenv_pkg::rsp_type duck_frame(adenv_pkg::req_type fr);
      longint unsigned g, goal, coef, span, step;
      logic [GAIN_BITS-1:0] applied;
      adenv_pkg::rsp_type res;
      g = env_gain;
      goal = adenv_pkg::UNITY_GAIN;
      if (fr.voice_active)
         goal = (live_cfg.duck_level > adenv_pkg::UNITY_GAIN) ? adenv_pkg::UNITY_GAIN
                                                              : live_cfg.duck_level;
      if (goal != g) begin
         coef = (goal < g) ? live_cfg.attack_coef : live_cfg.release_coef;
         if (coef > adenv_pkg::UNITY_GAIN) coef = adenv_pkg::UNITY_GAIN;
         span = (goal < g) ? g - goal : goal - g;
         step = (coef * span + 64'd32768) >> 16;
         // never stall short of the target, never overshoot it
         if (step == 0) step = 1;
         if (step > span) step = span;
         g = (goal < g) ? g - step : g + step;
      end
      env_gain = GAIN_BITS'(g);
      applied = live_cfg.duck_enable ? GAIN_BITS'(g) : adenv_pkg::UNITY_GAIN;
      res.left_out  = scale_sample(fr.left_in, live_cfg.base_volume, applied);
      res.right_out = scale_sample(fr.right_in, live_cfg.base_volume, applied);
      res.gain_out  = applied;
      return res;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0: return S_MAX;
         1: return S_MIN;
         2: return '0;
         3: return '1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return adenv_pkg::UNITY_GAIN;
         2: return CSR_DATA_BITS'($urandom_range(65537, 131071));
         3: return CSR_DATA_BITS'($urandom_range(1, 400));
         default: return CSR_DATA_BITS'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_volume();
      case ($urandom_range(0, 5))
         0: return CSR_DATA_BITS'(16'hFFFF);
         1: return CSR_DATA_BITS'(adenv_pkg::BASE_VOLUME_RST);
         2: return CSR_DATA_BITS'($urandom_range(0, 131071));  // upper bit dropped
         default: return CSR_DATA_BITS'($urandom_range(1024, 8192));
      endcase
   endfunction

   // Stop offering frames and wait until every outstanding beat has come back
   task automatic wait_for_drain();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (ducked_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      wait_for_drain();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         adenv_pkg::CSR_DUCK_ENABLE:  live_cfg.duck_enable  = val[0];
         adenv_pkg::CSR_DUCK_LEVEL:   live_cfg.duck_level   = val;
         adenv_pkg::CSR_ATTACK_COEF:  live_cfg.attack_coef  = val;
         adenv_pkg::CSR_RELEASE_COEF: live_cfg.release_coef = val;
         adenv_pkg::CSR_BASE_VOLUME:  live_cfg.base_volume  = val[VOL_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic send_frame(adenv_pkg::req_type fr, bit typed,
                             adenv_pkg::rsp_type typed_want);
      int gap;
      adenv_pkg::rsp_type predicted;
      gap = (steady || rx_hold) ? 0 : $urandom_range(0, MAX_GAP);
      if (csr_write_en) csr_write_en <= 1'b0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= fr;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predicted = duck_frame(fr);
      ducked_due.insert(ducked_due.size(), typed ? typed_want : predicted);
      frames_sent++;
   endtask

   task automatic set_phase(int p);
      logic [CSR_DATA_BITS-1:0] vals [NUM_REGS];
      case (p)
         0: vals = '{CSR_DATA_BITS'(1), CSR_DATA_BITS'(adenv_pkg::DUCK_LEVEL_RST),
                     CSR_DATA_BITS'(2000), CSR_DATA_BITS'(300),
                     CSR_DATA_BITS'(adenv_pkg::BASE_VOLUME_RST)};
         // fastest envelope, full depth, loudest volume
         1: vals = '{CSR_DATA_BITS'(1), CSR_DATA_BITS'(0),
                     CSR_DATA_BITS'(adenv_pkg::UNITY_GAIN),
                     CSR_DATA_BITS'(adenv_pkg::UNITY_GAIN), CSR_DATA_BITS'(16'hFFFF)};
         // clamped level, one-LSB steps, quietest volume
         2: vals = '{CSR_DATA_BITS'(1), CSR_DATA_BITS'(17'h1FFFF), CSR_DATA_BITS'(0),
                     CSR_DATA_BITS'(0), CSR_DATA_BITS'(1)};
         default: begin
            vals[0] = (p == 3) ? '0 : CSR_DATA_BITS'($urandom_range(0, 3) != 0);
            vals[1] = pick_gain();
            vals[2] = pick_gain();
            vals[3] = pick_gain();
            vals[4] = pick_volume();
         end
      endcase
      foreach (REG_ORDER[i]) set_reg(REG_ORDER[i], vals[i]);
      if ($urandom_range(0, 1))
         set_reg(CSR_IDX_BITS'($urandom_range(NUM_REGS, 2**CSR_IDX_BITS - 1)),
                 CSR_DATA_BITS'($urandom));
   endtask

   task automatic check_ducked(adenv_pkg::rsp_type got);
      adenv_pkg::rsp_type want;
      beats_checked++;
      if (ducked_due.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("%0t: beat with nothing outstanding: L=%0d R=%0d G=%0d",
                     $time, got.left_out, got.right_out, got.gain_out);
         return;
      end
      want = ducked_due.pop_front();
      if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
          got.gain_out !== want.gain_out) begin
         mismatches++;
         // later mismatches are counted only
         if (mismatches <= MAX_SHOWN)
            $display("%0t: beat %0d expected L=%0d R=%0d G=%0d, got L=%0d R=%0d G=%0d",
                     $time, beats_checked, want.left_out, want.right_out, want.gain_out,
                     got.left_out, got.right_out, got.gain_out);
      end
   endtask

   // Output check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_ducked(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("audio_ducking_envelope_tb: errors");
            $finish;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // Receiver: random stalls per beat, plus one long hold on request
   initial begin : rx_side
      int gap;
      forever begin
         if (rx_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rx_hold = 1'b0;
            holds_done++;
         end
         gap = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : stimulus
      adenv_pkg::req_type fr;
      int run_left;
      bit voice;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_REG) begin
            set_reg(script[i].idx, script[i].val);
         end else begin
            send_frame(script[i].frame, script[i].typed, script[i].want);
         end
      end

      // Random phases: voice runs of random length with a little flag noise
      run_left = 0;
      voice = 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_phase(p);
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            if (p == 2 && n == 40) rx_hold = 1'b1;
            if (n == PHASE_FRAMES / 2) wait_for_drain();
            if (run_left == 0) begin
               run_left = $urandom_range(1, 60);
               voice = ($urandom_range(0, 1) != 0);
            end
            run_left--;
            fr.left_in      = pick_sample();
            fr.right_in     = pick_sample();
            fr.voice_active = ($urandom_range(0, 9) == 0) ? ~voice : voice;
            send_frame(fr, 1'b0, NO_WANT);
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("summary: %0d frames in, %0d beats out checked, %0d register writes",
               frames_sent, beats_checked, reg_writes);
      $display("summary: %0d setting phases, %0d long output hold, %0d mismatches",
               NUM_PHASES, holds_done, mismatches);
      if (mismatches == 0 && ducked_due.size() == 0) begin
         $display("audio_ducking_envelope_tb: clean");
      end else begin
         $display("audio_ducking_envelope_tb: errors");
      end
      $finish;
   end

endmodule
